### rtl/i2c_tsb_pkg.sv
// shared types and constants of the i2c target setting bank
`timescale 1ns / 1ps

package i2c_tsb_pkg;

  // default sizes
  localparam int BANK_DEPTH_DEF  = 9;
  localparam int WRITE_SLOTS_DEF = 7;

  // fixed field widths
  localparam int FUNC_W  = 3;
  localparam int DATA_W  = 8;
  localparam int LIDX_W  = 4;
  localparam int CMD_W   = 2;
  localparam int PIDX_W  = 3;
  localparam int PVAL_W  = 10;
  localparam int EADDR_W = 3;
  localparam int SLOT_W  = 3;

  // configuration reset values
  localparam logic [DATA_W-1:0] MAX_DUTY_RST = 8'd255;
  localparam logic [DATA_W-1:0] TEMP_LIM_RST = 8'd250;

  // offset parameter is published as byte minus this bias
  localparam logic [PVAL_W-1:0] OFFSET_BIAS = 10'd127;

  typedef enum logic [0:0] {
    CFG_MAX_DUTY = 1'b0,
    CFG_TEMP_LIM = 1'b1
  } cfg_idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADDR_MATCH = 3'd0,
    FUNC_STOP       = 3'd1,
    FUNC_WRITE      = 3'd2,
    FUNC_READ       = 3'd3,
    FUNC_LOCAL_WR   = 3'd4
  } func_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACK      = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_NACK     = 2'd2,
    CMD_NOACT    = 2'd3
  } cmd_t;

  // write slots
  localparam logic [SLOT_W-1:0] SLOT_SETPOINT = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_MAX_DUTY = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_DEF_TEMP = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_IDLE_SEC = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_OFF_MIN  = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_OFFSET   = 3'd6;

  // bank entries fed by the write slots
  localparam logic [LIDX_W-1:0] BANK_SETPOINT = 4'd3;
  localparam logic [LIDX_W-1:0] BANK_MAX_DUTY = 4'd4;
  localparam logic [LIDX_W-1:0] BANK_DEF_TEMP = 4'd5;
  localparam logic [LIDX_W-1:0] BANK_IDLE_SEC = 4'd6;
  localparam logic [LIDX_W-1:0] BANK_OFF_MIN  = 4'd7;
  localparam logic [LIDX_W-1:0] BANK_OFFSET   = 4'd8;

  // live parameter indexes
  localparam logic [PIDX_W-1:0] PAR_SETPOINT = 3'd0;
  localparam logic [PIDX_W-1:0] PAR_MAX_DUTY = 3'd1;
  localparam logic [PIDX_W-1:0] PAR_IDLE_SEC = 3'd2;
  localparam logic [PIDX_W-1:0] PAR_OFF_MIN  = 3'd3;
  localparam logic [PIDX_W-1:0] PAR_OFFSET   = 3'd4;

  // eeprom addresses
  localparam logic [EADDR_W-1:0] EE_MAX_DUTY = 3'd1;
  localparam logic [EADDR_W-1:0] EE_DEF_TEMP = 3'd2;
  localparam logic [EADDR_W-1:0] EE_IDLE_SEC = 3'd3;
  localparam logic [EADDR_W-1:0] EE_OFF_MIN  = 3'd4;
  localparam logic [EADDR_W-1:0] EE_OFFSET   = 3'd5;

endpackage

### rtl/i2c_target_setting_bank_core.sv
// i2c target transaction logic for a setting and status bank
//
// usage: one bus event per input transaction (address match, stop, byte
// written by the controller, byte requested by the controller, local bank
// write). every event gives exactly one result transaction carrying the
// bus command, an optional byte to transmit, an optional live parameter
// update and an optional eeprom store request.
// the event lands in an input register, then the write and read counters
// and the bank are updated while the result is loaded into the output
// register. throughput is one event per cycle unless the receiver stalls.
// the user must write the limit registers on the cfg_ port only while idle;
// the block itself does not enforce it. reset (rst_n low, synchronous)
// clears both counters, the whole bank and the valid bits of both pipeline
// registers, and loads the limit defaults. when the receiver stalls, the
// result holds and one more event can still sit in the input register;
// in_stall rises only when both are full.
`timescale 1ns / 1ps

module i2c_target_setting_bank_core #(
  parameter int BANK_DEPTH  = i2c_tsb_pkg::BANK_DEPTH_DEF,
  parameter int WRITE_SLOTS = i2c_tsb_pkg::WRITE_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [i2c_tsb_pkg::DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [i2c_tsb_pkg::FUNC_W-1:0]        in_func,
  input  logic [i2c_tsb_pkg::DATA_W-1:0]        in_data,
  input  logic                                  in_master_nack,
  input  logic [i2c_tsb_pkg::LIDX_W-1:0]        in_local_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [i2c_tsb_pkg::CMD_W-1:0]         out_bus_command,
  output logic                                  out_tx_valid,
  output logic [i2c_tsb_pkg::DATA_W-1:0]        out_tx_data,
  output logic                                  out_param_valid,
  output logic [i2c_tsb_pkg::PIDX_W-1:0]        out_param_index,
  output logic signed [i2c_tsb_pkg::PVAL_W-1:0] out_param_value,
  output logic                                  out_eeprom_valid,
  output logic [i2c_tsb_pkg::EADDR_W-1:0]       out_eeprom_addr,
  output logic [i2c_tsb_pkg::DATA_W-1:0]        out_eeprom_data
);
  import i2c_tsb_pkg::*;

  localparam int WC_W = $clog2(WRITE_SLOTS + 1);
  localparam int RC_W = $clog2(BANK_DEPTH + 1);
  localparam int BI_W = $clog2(BANK_DEPTH);

  // limit registers
  logic [DATA_W-1:0] max_duty_r;
  logic [DATA_W-1:0] temp_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_duty_r <= MAX_DUTY_RST;
      temp_lim_r <= TEMP_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_DUTY: max_duty_r <= cfg_wdata;
        CFG_TEMP_LIM: temp_lim_r <= cfg_wdata;
      endcase
    end
  end

  // input register
  logic              s1_vld_r;
  logic [FUNC_W-1:0] s1_func_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_nack_r;
  logic [LIDX_W-1:0] s1_lidx_r;

  logic out_vld_r;
  logic out_free;
  logic advance;

  assign out_free = !out_vld_r || !out_stall;
  assign advance  = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func_r <= in_func;
      s1_data_r <= in_data;
      s1_nack_r <= in_master_nack;
      s1_lidx_r <= in_local_index;
    end
  end

  // transaction state
  logic [WC_W-1:0]   wr_cnt_r, wr_cnt_nxt;
  logic [RC_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [DATA_W-1:0] bank_r   [BANK_DEPTH];
  logic [DATA_W-1:0] bank_nxt [BANK_DEPTH];

  // event decode
  logic                bank_we;
  logic [LIDX_W-1:0]   bank_widx;
  logic [SLOT_W-1:0]   slot;
  logic [CMD_W-1:0]    cmd_nxt;
  logic                txv_nxt;
  logic [DATA_W-1:0]   txd_nxt;
  logic                pv_nxt;
  logic [PIDX_W-1:0]   pi_nxt;
  logic [PVAL_W-1:0]   pval_nxt;
  logic                ev_nxt;
  logic [EADDR_W-1:0]  ea_nxt;
  logic [DATA_W-1:0]   ed_nxt;

  assign slot = SLOT_W'(wr_cnt_r);

  always_comb begin
    cmd_nxt    = CMD_NOACT;
    txv_nxt    = 1'b0;
    txd_nxt    = '0;
    pv_nxt     = 1'b0;
    pi_nxt     = '0;
    pval_nxt   = '0;
    ev_nxt     = 1'b0;
    ea_nxt     = '0;
    ed_nxt     = '0;
    wr_cnt_nxt = wr_cnt_r;
    rd_cnt_nxt = rd_cnt_r;
    bank_we    = 1'b0;
    bank_widx  = '0;
    unique case (s1_func_r)
      FUNC_ADDR_MATCH: begin
        cmd_nxt = CMD_ACK;
      end
      FUNC_STOP: begin
        cmd_nxt    = CMD_COMPLETE;
        wr_cnt_nxt = '0;
        rd_cnt_nxt = '0;
      end
      FUNC_WRITE: begin
        if (wr_cnt_r < WC_W'(WRITE_SLOTS)) begin
          cmd_nxt    = CMD_ACK;
          wr_cnt_nxt = wr_cnt_r + 1'b1;
          // rejected bytes are still acked and still use their slot
          unique case (slot)
            SLOT_SETPOINT: begin
              if (s1_data_r <= temp_lim_r) begin
                bank_we   = 1'b1;
                bank_widx = BANK_SETPOINT;
                pv_nxt    = 1'b1;
                pi_nxt    = PAR_SETPOINT;
                pval_nxt  = {1'b0, s1_data_r, 1'b0};
              end
            end
            SLOT_MAX_DUTY: begin
              if (s1_data_r < max_duty_r) begin
                bank_we   = 1'b1;
                bank_widx = BANK_MAX_DUTY;
                pv_nxt    = 1'b1;
                pi_nxt    = PAR_MAX_DUTY;
                pval_nxt  = PVAL_W'(s1_data_r);
                ev_nxt    = 1'b1;
                ea_nxt    = EE_MAX_DUTY;
                ed_nxt    = s1_data_r;
              end
            end
            SLOT_DEF_TEMP: begin
              if (s1_data_r <= temp_lim_r) begin
                bank_we   = 1'b1;
                bank_widx = BANK_DEF_TEMP;
                ev_nxt    = 1'b1;
                ea_nxt    = EE_DEF_TEMP;
                ed_nxt    = s1_data_r;
              end
            end
            SLOT_IDLE_SEC: begin
              bank_we   = 1'b1;
              bank_widx = BANK_IDLE_SEC;
              pv_nxt    = 1'b1;
              pi_nxt    = PAR_IDLE_SEC;
              pval_nxt  = PVAL_W'(s1_data_r);
              ev_nxt    = 1'b1;
              ea_nxt    = EE_IDLE_SEC;
              ed_nxt    = s1_data_r;
            end
            SLOT_OFF_MIN: begin
              bank_we   = 1'b1;
              bank_widx = BANK_OFF_MIN;
              pv_nxt    = 1'b1;
              pi_nxt    = PAR_OFF_MIN;
              pval_nxt  = PVAL_W'(s1_data_r);
              ev_nxt    = 1'b1;
              ea_nxt    = EE_OFF_MIN;
              ed_nxt    = s1_data_r;
            end
            SLOT_OFFSET: begin
              bank_we   = 1'b1;
              bank_widx = BANK_OFFSET;
              pv_nxt    = 1'b1;
              pi_nxt    = PAR_OFFSET;
              pval_nxt  = PVAL_W'(s1_data_r) - OFFSET_BIAS;
              ev_nxt    = 1'b1;
              ea_nxt    = EE_OFFSET;
              ed_nxt    = s1_data_r;
            end
            default: begin
              // first byte and any slot past the offset: only counted
            end
          endcase
        end else begin
          cmd_nxt = CMD_NACK;
        end
      end
      FUNC_READ: begin
        priority if (rd_cnt_r != '0 && s1_nack_r) begin
          cmd_nxt = CMD_COMPLETE;
        end else if (rd_cnt_r < RC_W'(BANK_DEPTH)) begin
          cmd_nxt    = CMD_ACK;
          txv_nxt    = 1'b1;
          txd_nxt    = bank_r[rd_cnt_r[BI_W-1:0]];
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end else begin
          cmd_nxt    = CMD_COMPLETE;
          rd_cnt_nxt = '0;
        end
      end
      FUNC_LOCAL_WR: begin
        bank_we   = 1'b1;
        bank_widx = s1_lidx_r;
      end
      default: begin
      end
    endcase
  end

  // bank entries past the depth are never written
  always_comb begin
    for (int i = 0; i < BANK_DEPTH; i++) begin
      bank_nxt[i] = bank_r[i];
      if (bank_we && bank_widx == LIDX_W'(i)) begin
        bank_nxt[i] = s1_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cnt_r <= '0;
      rd_cnt_r <= '0;
      for (int i = 0; i < BANK_DEPTH; i++) begin
        bank_r[i] <= '0;
      end
    end else if (advance) begin
      wr_cnt_r <= wr_cnt_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      for (int i = 0; i < BANK_DEPTH; i++) begin
        bank_r[i] <= bank_nxt[i];
      end
    end
  end

  // result register
  logic [CMD_W-1:0]   cmd_r;
  logic               txv_r;
  logic [DATA_W-1:0]  txd_r;
  logic               pv_r;
  logic [PIDX_W-1:0]  pi_r;
  logic [PVAL_W-1:0]  pval_r;
  logic               ev_r;
  logic [EADDR_W-1:0] ea_r;
  logic [DATA_W-1:0]  ed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_r  <= cmd_nxt;
      txv_r  <= txv_nxt;
      txd_r  <= txd_nxt;
      pv_r   <= pv_nxt;
      pi_r   <= pi_nxt;
      pval_r <= pval_nxt;
      ev_r   <= ev_nxt;
      ea_r   <= ea_nxt;
      ed_r   <= ed_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_bus_command  = cmd_r;
  assign out_tx_valid     = txv_r;
  assign out_tx_data      = txd_r;
  assign out_param_valid  = pv_r;
  assign out_param_index  = pi_r;
  assign out_param_value  = signed'(pval_r);
  assign out_eeprom_valid = ev_r;
  assign out_eeprom_addr  = ea_r;
  assign out_eeprom_data  = ed_r;

endmodule

### rtl/i2c_tsb_checker.sv
// port-level checks for the i2c target setting bank, bound to the top level
`timescale 1ns / 1ps

module i2c_tsb_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [i2c_tsb_pkg::CMD_W-1:0]         out_bus_command,
  input logic                                  out_tx_valid,
  input logic                                  out_param_valid,
  input logic [i2c_tsb_pkg::PIDX_W-1:0]        out_param_index,
  input logic signed [i2c_tsb_pkg::PVAL_W-1:0] out_param_value,
  input logic                                  out_eeprom_valid,
  input logic [i2c_tsb_pkg::EADDR_W-1:0]       out_eeprom_addr
);
  import i2c_tsb_pkg::*;

  // a stalled result transaction holds its command
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bus_command))
    else $error("result changed while stalled");

  // a transmitted byte always comes with an ack and without a store request
  a_tx_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_bus_command == CMD_ACK && !out_eeprom_valid)
    else $error("tx byte without ack");

  // a store request comes from an acked write with a nonzero address
  a_ee_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_eeprom_valid |->
      out_bus_command == CMD_ACK && out_eeprom_addr != '0)
    else $error("eeprom request outside an acked write");

  // the setpoint parameter is an even non-negative value
  a_setpoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_param_valid && out_param_index == PAR_SETPOINT |->
      !out_param_value[0] && out_param_value >= 0)
    else $error("bad setpoint parameter");

  // after reset the result is empty and the input side does not stall
  a_no_stall: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind i2c_target_setting_bank_core i2c_tsb_checker u_i2c_tsb_checker (.*);
